FILE: sv/stt_pkg.sv
// ============================================================================
// stt_pkg - shared types and constants of the source text tokenizer
// Token codes, character constants, result and batch records, helpers.
// ============================================================================
package stt_pkg;

  localparam int POS_BITS  = 16;
  localparam int MAX_RES   = 6;
  localparam int CNT_BITS  = $clog2(MAX_RES + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_ID      = 4'd1,
    ST_ID_U    = 4'd2,
    ST_WHOLE   = 4'd3,
    ST_WHOLE_E = 4'd4,
    ST_FRAC0   = 4'd5,
    ST_FRAC    = 4'd6,
    ST_EXP0    = 4'd7,
    ST_EXP_SGN = 4'd8,
    ST_EXP     = 4'd9,
    ST_STR     = 4'd10,
    ST_STR_BS  = 4'd11,
    ST_OP      = 4'd12
  } lex_state_t;

  // result kinds
  localparam logic [1:0] RK_VALUE  = 2'd0;
  localparam logic [1:0] RK_RECORD = 2'd1;
  localparam logic [1:0] RK_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd0;
  localparam logic [2:0] ERR_UNDERSCORE = 3'd1;
  localparam logic [2:0] ERR_EXP_SIGN   = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd3;
  localparam logic [2:0] ERR_ESCAPE     = 3'd4;

  // token codes
  localparam logic [5:0] TK_ID      = 6'd0;
  localparam logic [5:0] TK_INT     = 6'd1;
  localparam logic [5:0] TK_FLOAT   = 6'd2;
  localparam logic [5:0] TK_STRING  = 6'd3;
  localparam logic [5:0] TK_PLUS    = 6'd4;
  localparam logic [5:0] TK_MINUS   = 6'd5;
  localparam logic [5:0] TK_MULT    = 6'd6;
  localparam logic [5:0] TK_DIVIDE  = 6'd7;
  localparam logic [5:0] TK_CARET   = 6'd8;
  localparam logic [5:0] TK_LPAREN  = 6'd9;
  localparam logic [5:0] TK_RPAREN  = 6'd10;
  localparam logic [5:0] TK_NEWLINE = 6'd11;
  localparam logic [5:0] TK_COMMA   = 6'd12;
  localparam logic [5:0] TK_SEMI    = 6'd13;
  localparam logic [5:0] TK_LSQUARE = 6'd14;
  localparam logic [5:0] TK_RSQUARE = 6'd15;
  localparam logic [5:0] TK_LCURLY  = 6'd16;
  localparam logic [5:0] TK_RCURLY  = 6'd17;
  localparam logic [5:0] TK_DOT     = 6'd18;
  localparam logic [5:0] TK_EQ      = 6'd19;
  localparam logic [5:0] TK_NE      = 6'd20;
  localparam logic [5:0] TK_LE      = 6'd21;
  localparam logic [5:0] TK_GE      = 6'd22;
  localparam logic [5:0] TK_AND     = 6'd23;
  localparam logic [5:0] TK_OR      = 6'd24;
  localparam logic [5:0] TK_DCOLON  = 6'd25;
  localparam logic [5:0] TK_ASSIGN  = 6'd26;
  localparam logic [5:0] TK_NOT     = 6'd27;
  localparam logic [5:0] TK_LT      = 6'd28;
  localparam logic [5:0] TK_GT      = 6'd29;
  localparam logic [5:0] TK_AMP     = 6'd30;
  localparam logic [5:0] TK_BAR     = 6'd31;
  localparam logic [5:0] TK_COLON   = 6'd32;
  localparam logic [5:0] TK_EOF     = 6'd34;
  localparam logic [5:0] TK_NONE    = 6'd63;

  // characters
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  vbyte;
    logic [5:0]  tkind;
    logic [15:0] tstart;
    logic [15:0] tlen;
    logic [2:0]  ecode;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]  r;
    logic [CNT_BITS-1:0] cnt;
  } batch_t;

  function automatic logic is_alpha(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= 8'h61) && (l <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic pos_t sat_dec(input pos_t v);
    return (v == '0) ? v : v - pos_t'(1);
  endfunction

  function automatic logic [15:0] clamp16(input pos_t v);
    logic [POS_BITS+15:0] w;
    w = {16'b0, v};
    return (w > (POS_BITS+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic res_t mk_val(input logic [7:0] b);
    res_t r;
    r = '0;
    r.kind  = RK_VALUE;
    r.vbyte = b;
    return r;
  endfunction

  function automatic res_t mk_rec(input logic [5:0] k, input pos_t s, input pos_t l);
    res_t r;
    r = '0;
    r.kind   = RK_RECORD;
    r.tkind  = k;
    r.tstart = clamp16(s);
    r.tlen   = clamp16(l);
    return r;
  endfunction

  function automatic res_t mk_err(input logic [2:0] e, input pos_t p);
    res_t r;
    r = '0;
    r.kind   = RK_ERROR;
    r.ecode  = e;
    r.tstart = clamp16(p);
    return r;
  endfunction

  // one-char operator held in the operator state
  function automatic logic [5:0] pend_code(input logic [7:0] f);
    logic [5:0] k;
    unique case (f)
      CH_EQ:   k = TK_ASSIGN;
      CH_BANG: k = TK_NOT;
      CH_LT:   k = TK_LT;
      CH_GT:   k = TK_GT;
      CH_AMP:  k = TK_AMP;
      CH_BAR:  k = TK_BAR;
      default: k = TK_COLON;
    endcase
    return k;
  endfunction

  // punctuation finished by one char; TK_NONE if not one
  function automatic logic [5:0] punct_code(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      CH_PLUS:  k = TK_PLUS;
      CH_MINUS: k = TK_MINUS;
      8'h2a:    k = TK_MULT;
      8'h2f:    k = TK_DIVIDE;
      8'h5e:    k = TK_CARET;
      8'h28:    k = TK_LPAREN;
      8'h29:    k = TK_RPAREN;
      CH_LF:    k = TK_NEWLINE;
      8'h2c:    k = TK_COMMA;
      8'h3b:    k = TK_SEMI;
      8'h5b:    k = TK_LSQUARE;
      8'h5d:    k = TK_RSQUARE;
      8'h7b:    k = TK_LCURLY;
      8'h7d:    k = TK_RCURLY;
      CH_DOT:   k = TK_DOT;
      default:  k = TK_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/stt_front.sv
// ============================================================================
// stt_front - lexer state step
// Takes one byte or end marker per word and writes its results as one batch.
// ============================================================================
module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output logic       push,
  output batch_t     wdata
);

  lex_state_t st_r, st_nxt;
  logic [7:0] pfc_r, pfc_nxt;
  logic       isf_r, isf_nxt;
  pos_t       sp_r, sp_nxt;
  pos_t       ln_r, ln_nxt;
  pos_t       bpos_r, bpos_nxt;

  res_t [MAX_RES-1:0]  rs;
  logic [CNT_BITS-1:0] n;

  always_comb begin
    logic [7:0] c;
    pos_t       pos;
    pos_t       ps;
    logic       do_start;
    logic       idc;
    logic [5:0] nk;
    logic [5:0] code;
    logic [5:0] pk;
    c        = char_byte;
    pos      = bpos_r;
    st_nxt   = st_r;
    pfc_nxt  = pfc_r;
    isf_nxt  = isf_r;
    sp_nxt   = sp_r;
    ln_nxt   = ln_r;
    bpos_nxt = sat_inc(bpos_r);
    rs       = '0;
    n        = '0;
    do_start = 1'b0;
    idc      = (c == CH_USCORE) || is_alpha(c) || is_digit(c);
    nk       = isf_r ? TK_FLOAT : TK_INT;
    code     = TK_NONE;
    ps       = sat_dec(pos);
    pk       = punct_code(c);
    if (end_of_input) begin
      unique case (st_r)
        ST_ID, ST_ID_U: begin
          rs[n] = mk_rec(TK_ID, sp_r, ln_r); n = n + 1'b1;
        end
        ST_WHOLE, ST_FRAC0, ST_FRAC, ST_EXP0, ST_EXP: begin
          rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1;
        end
        ST_WHOLE_E: begin
          rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1;
          rs[n] = mk_val(CH_E); n = n + 1'b1;
          rs[n] = mk_rec(TK_ID, ps, pos_t'(1)); n = n + 1'b1;
          sp_nxt = ps;
          ln_nxt = pos_t'(1);
        end
        ST_EXP_SGN: begin
          rs[n] = mk_err(ERR_EXP_SIGN, pos); n = n + 1'b1;
        end
        ST_STR, ST_STR_BS: begin
          rs[n] = mk_err(ERR_UNCLOSED, pos); n = n + 1'b1;
        end
        ST_OP: begin
          rs[n] = mk_rec(pend_code(pfc_r), sp_r, pos_t'(1)); n = n + 1'b1;
        end
        default: ;
      endcase
      rs[n] = mk_rec(TK_EOF, pos, '0); n = n + 1'b1;
      st_nxt   = ST_START;
      isf_nxt  = 1'b0;
      bpos_nxt = '0;
    end else begin
      unique case (st_r)
        ST_ID: begin
          if (idc) begin
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else begin
            rs[n] = mk_rec(TK_ID, sp_r, ln_r); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_ID_U: begin
          if (c == CH_USCORE || is_digit(c)) begin
            rs[n] = mk_err(ERR_UNDERSCORE, pos); n = n + 1'b1; st_nxt = ST_START;
          end else if (is_alpha(c)) begin
            st_nxt = ST_ID;
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else begin
            rs[n] = mk_rec(TK_ID, sp_r, ln_r); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_WHOLE: begin
          if (is_digit(c)) begin
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else if (c == CH_DOT) begin
            st_nxt = ST_FRAC0; isf_nxt = 1'b1;
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else if (c == CH_E) begin
            st_nxt = ST_WHOLE_E;
          end else begin
            rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_WHOLE_E: begin
          if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
            // exponent confirmed: emit held e, then this byte
            isf_nxt = 1'b1;
            rs[n] = mk_val(CH_E); n = n + 1'b1;
            rs[n] = mk_val(c); n = n + 1'b1;
            ln_nxt = sat_inc(sat_inc(ln_r));
            st_nxt = is_digit(c) ? ST_EXP : ST_EXP_SGN;
          end else begin
            // integer ends; held e starts an identifier
            rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1;
            rs[n] = mk_val(CH_E); n = n + 1'b1;
            sp_nxt = ps;
            st_nxt = ST_ID;
            if (idc) begin
              rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = pos_t'(2);
            end else begin
              ln_nxt = pos_t'(1);
              rs[n] = mk_rec(TK_ID, ps, pos_t'(1)); n = n + 1'b1; do_start = 1'b1;
            end
          end
        end
        ST_FRAC0: begin
          if (is_digit(c)) begin
            st_nxt = ST_FRAC;
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else begin
            rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_FRAC: begin
          if (is_digit(c)) begin
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else if (c == CH_E) begin
            st_nxt = ST_EXP0;
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else begin
            rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_EXP0: begin
          if (is_digit(c)) begin
            st_nxt = ST_EXP;
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            st_nxt = ST_EXP_SGN;
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else begin
            rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_EXP_SGN: begin
          if (is_digit(c)) begin
            st_nxt = ST_EXP;
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else begin
            rs[n] = mk_err(ERR_EXP_SIGN, pos); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_EXP: begin
          if (is_digit(c)) begin
            rs[n] = mk_val(c); n = n + 1'b1; ln_nxt = sat_inc(ln_r);
          end else begin
            rs[n] = mk_rec(nk, sp_r, ln_r); n = n + 1'b1; do_start = 1'b1;
          end
        end
        ST_STR: begin
          ln_nxt = sat_inc(ln_r);
          if (c == CH_BSLASH) begin
            st_nxt = ST_STR_BS;
          end else if (c == CH_QUOTE) begin
            rs[n] = mk_rec(TK_STRING, sp_r, sat_inc(ln_r)); n = n + 1'b1;
            st_nxt = ST_START;
          end else begin
            rs[n] = mk_val(c); n = n + 1'b1;
          end
        end
        ST_STR_BS: begin
          if (c == CH_BSLASH || c == CH_N || c == CH_R) begin
            ln_nxt = sat_inc(ln_r);
            rs[n] = mk_val((c == CH_N) ? CH_LF : ((c == CH_R) ? CH_CR : c));
            n = n + 1'b1;
            st_nxt = ST_STR;
          end else begin
            rs[n] = mk_err(ERR_ESCAPE, pos); n = n + 1'b1; st_nxt = ST_START;
          end
        end
        ST_OP: begin
          if (c == CH_EQ) begin
            priority case (pfc_r)
              CH_EQ:   code = TK_EQ;
              CH_BANG: code = TK_NE;
              CH_LT:   code = TK_LE;
              CH_GT:   code = TK_GE;
              default: code = TK_NONE;
            endcase
          end else if (c == pfc_r) begin
            priority case (pfc_r)
              CH_AMP:   code = TK_AND;
              CH_BAR:   code = TK_OR;
              CH_COLON: code = TK_DCOLON;
              default:  code = TK_NONE;
            endcase
          end
          if (code != TK_NONE) begin
            rs[n] = mk_val(pfc_r); n = n + 1'b1;
            rs[n] = mk_val(c); n = n + 1'b1;
            ln_nxt = pos_t'(2);
            rs[n] = mk_rec(code, sp_r, pos_t'(2)); n = n + 1'b1;
            st_nxt = ST_START;
          end else begin
            rs[n] = mk_rec(pend_code(pfc_r), sp_r, pos_t'(1)); n = n + 1'b1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      // byte that ends a token is lexed again from the start state
      if (do_start) begin
        st_nxt = ST_START;
        if (is_alpha(c)) begin
          st_nxt = ST_ID; sp_nxt = pos; ln_nxt = pos_t'(1);
          rs[n] = mk_val(c); n = n + 1'b1;
        end else if (c == CH_USCORE) begin
          st_nxt = ST_ID_U; sp_nxt = pos; ln_nxt = pos_t'(1);
          rs[n] = mk_val(c); n = n + 1'b1;
        end else if (is_digit(c)) begin
          st_nxt = ST_WHOLE; sp_nxt = pos; ln_nxt = pos_t'(1); isf_nxt = 1'b0;
          rs[n] = mk_val(c); n = n + 1'b1;
        end else if (c == CH_QUOTE) begin
          st_nxt = ST_STR; sp_nxt = pos; ln_nxt = pos_t'(1);
        end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
                     c == CH_AMP || c == CH_BAR || c == CH_COLON) begin
          st_nxt = ST_OP; sp_nxt = pos; ln_nxt = pos_t'(1); pfc_nxt = c;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          st_nxt = ST_START;
        end else if (pk != TK_NONE) begin
          rs[n] = mk_rec(pk, pos, pos_t'(1)); n = n + 1'b1;
        end else begin
          rs[n] = mk_err(ERR_BAD_CHAR, pos); n = n + 1'b1;
        end
      end
    end
  end

  assign push      = fire && (n != '0);
  assign wdata.r   = rs;
  assign wdata.cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_START;
      pfc_r  <= '0;
      isf_r  <= 1'b0;
      sp_r   <= '0;
      ln_r   <= '0;
      bpos_r <= '0;
    end else if (fire) begin
      st_r   <= st_nxt;
      pfc_r  <= pfc_nxt;
      isf_r  <= isf_nxt;
      sp_r   <= sp_nxt;
      ln_r   <= ln_nxt;
      bpos_r <= bpos_nxt;
    end
  end

endmodule

FILE: sv/stt_queue.sv
// ============================================================================
// stt_queue - batch queue between front and back
// Short register FIFO of result batches.
// ============================================================================
module stt_queue import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  batch_t wdata,
  input  logic   pop,
  output batch_t rdata,
  output logic   empty,
  output logic   full
);

  batch_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wp_r, wp_nxt;
  logic [QPTR_BITS-1:0]   rp_r, rp_nxt;
  logic [QPTR_BITS:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QPTR_BITS+1)'(QDEPTH));
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: sv/stt_back.sv
// ============================================================================
// stt_back - result sequencer
// Walks the head batch one result per word into the output register.
// ============================================================================
module stt_back import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  batch_t head,
  input  logic   empty,
  output logic   pop,
  input  logic   out_stall,
  output logic   out_valid,
  output res_t   out_res,
  output logic   out_last
);

  logic [CNT_BITS-1:0] idx_r, idx_nxt;
  logic                vld_r, vld_nxt;
  res_t                res_r, res_nxt;
  logic                last_r, last_nxt;
  logic                load;
  logic                at_end;

  assign load   = !empty && (!vld_r || !out_stall);
  assign at_end = (idx_r == head.cnt - 1'b1);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt  = idx_r;
    res_nxt  = res_r;
    last_nxt = last_r;
    vld_nxt  = vld_r && out_stall;
    if (load) begin
      res_nxt  = head.r[idx_r];
      last_nxt = at_end;
      vld_nxt  = 1'b1;
      idx_nxt  = at_end ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

FILE: sv/source_text_tokenizer_unit.sv
// ============================================================================
// source_text_tokenizer_unit - byte-serial source lexer
// Front lexer step, batch queue and result sequencer.
// ============================================================================
// Takes one source byte (or an end marker) per word and returns, per byte,
// zero to four result words: value bytes of the token in progress, finished
// token records (type, start, length) and error reports; the last word of a
// byte carries out_last_of_run. A byte is taken every cycle while the
// four-entry batch queue has room; results leave at one word per cycle while
// out_stall is low, so bytes that make several results fill the queue and
// in_stall rises until the output catches up. The first result word of a byte
// passes through the batch queue and the output register before it is offered.
module source_text_tokenizer_unit import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value_byte,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  logic   fire;
  logic   q_push, q_pop, q_empty, q_full;
  batch_t q_wdata, q_rdata;
  res_t   res;

  // accept whenever the queue can take a batch
  assign in_stall = q_full;
  assign fire     = in_valid && !q_full;

  stt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .char_byte    (in_char_byte),
    .end_of_input (in_end_of_input),
    .push         (q_push),
    .wdata        (q_wdata)
  );

  stt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rdata),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res),
    .out_last  (out_last_of_run)
  );

  assign out_kind         = res.kind;
  assign out_value_byte   = res.vbyte;
  assign out_token_kind   = res.tkind;
  assign out_token_start  = res.tstart;
  assign out_token_length = res.tlen;
  assign out_error_code   = res.ecode;

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("batch pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("batch popped from empty queue");
  a_batch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.cnt != '0)) else $error("empty batch queued");
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last_of_run)) else $error("batch end without last flag");
`endif

endmodule

FILE: verif/stt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// stt_checker - result predictor and scoreboard for the tokenizer
// Watches accepted bytes, predicts the result words and compares them.
// ============================================================================
module stt_checker import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_value_byte,
  input  logic [5:0]  out_token_kind,
  input  logic [15:0] out_token_start,
  input  logic [15:0] out_token_length,
  input  logic [2:0]  out_error_code,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    res_t r;
    logic last;
  } word_t;

  word_t      expected_words[$];
  word_t      step_words[$];
  lex_state_t lx_state;
  logic [7:0] op_first;
  logic       num_float;
  pos_t       tok_start, tok_len, src_pos;

  function automatic logic alpha_c(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function automatic logic digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic pos_t inc_sat(pos_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic push(logic [1:0] k, logic [7:0] vb, logic [5:0] tk, pos_t st, pos_t ln,
                      logic [2:0] ec);
    word_t w;
    w = '0;
    w.r.kind = k; w.r.vbyte = vb; w.r.tkind = tk;
    w.r.tstart = st; w.r.tlen = ln; w.r.ecode = ec;
    if (step_words.size() < MAX_RES) step_words.push_back(w);
  endtask

  task automatic put_byte(logic [7:0] b);
    push(RK_VALUE, b, 0, 0, 0, 0);
  endtask

  task automatic put_token(logic [5:0] k, pos_t st, pos_t ln);
    push(RK_RECORD, 0, k, st, ln, 0);
  endtask

  task automatic put_error(logic [2:0] e, pos_t p);
    push(RK_ERROR, 0, 0, p, 0, e);
  endtask

  function automatic logic [5:0] single_op(logic [7:0] f);
    case (f)
      CH_EQ:   return TK_ASSIGN;
      CH_BANG: return TK_NOT;
      CH_LT:   return TK_LT;
      CH_GT:   return TK_GT;
      CH_AMP:  return TK_AMP;
      CH_BAR:  return TK_BAR;
      default: return TK_COLON;
    endcase
  endfunction

  task automatic open_tok(lex_state_t s, pos_t p);
    lx_state = s; tok_start = p; tok_len = 1;
  endtask

  task automatic keep_byte(logic [7:0] c);
    put_byte(c);
    tok_len = inc_sat(tok_len);
  endtask

  task automatic close_tok(logic [5:0] k);
    put_token(k, tok_start, tok_len);
    lx_state = ST_START;
  endtask

  function automatic logic [5:0] num_kind();
    return num_float ? TK_FLOAT : TK_INT;
  endfunction

  task automatic scan_start(logic [7:0] c, pos_t p);
    logic [5:0] k;
    lx_state = ST_START;
    if (alpha_c(c)) begin open_tok(ST_ID, p); put_byte(c); end
    else if (c == CH_USCORE) begin open_tok(ST_ID_U, p); put_byte(c); end
    else if (digit_c(c)) begin open_tok(ST_WHOLE, p); num_float = 0; put_byte(c); end
    else if (c == CH_QUOTE) open_tok(ST_STR, p);
    else if (c inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR, CH_COLON}) begin
      open_tok(ST_OP, p);
      op_first = c;
    end else if (c == CH_SPACE || c == CH_TAB) begin
    end else begin
      case (c)
        "+":   k = TK_PLUS;     "-": k = TK_MINUS;   "*": k = TK_MULT;
        "/":   k = TK_DIVIDE;   "^": k = TK_CARET;   "(": k = TK_LPAREN;
        ")":   k = TK_RPAREN;   ",": k = TK_COMMA;   ";": k = TK_SEMI;
        "[":   k = TK_LSQUARE;  "]": k = TK_RSQUARE; "{": k = TK_LCURLY;
        "}":   k = TK_RCURLY;   ".": k = TK_DOT;
        CH_LF: k = TK_NEWLINE;
        default: k = TK_NONE;
      endcase
      if (k == TK_NONE) put_error(ERR_BAD_CHAR, p);
      else put_token(k, p, 1);
    end
  endtask

  // one byte through the lexer; the e lookahead recurses once
  task automatic scan_byte(logic [7:0] c, pos_t p);
    logic [5:0] k;
    case (lx_state)
      ST_ID:
        if (c == CH_USCORE || alpha_c(c) || digit_c(c)) keep_byte(c);
        else begin close_tok(TK_ID); scan_start(c, p); end
      ST_ID_U:
        if (c == CH_USCORE || digit_c(c)) begin
          put_error(ERR_UNDERSCORE, p); lx_state = ST_START;
        end else if (alpha_c(c)) begin lx_state = ST_ID; keep_byte(c); end
        else begin close_tok(TK_ID); scan_start(c, p); end
      ST_WHOLE:
        if (digit_c(c)) keep_byte(c);
        else if (c == CH_DOT) begin lx_state = ST_FRAC0; num_float = 1; keep_byte(c); end
        else if (c == CH_E) lx_state = ST_WHOLE_E;
        else begin close_tok(num_kind()); scan_start(c, p); end
      ST_WHOLE_E:
        if (digit_c(c) || c == CH_PLUS || c == CH_MINUS) begin
          num_float = 1; keep_byte(CH_E); lx_state = ST_EXP0;
          scan_byte(c, p);
        end else begin
          close_tok(num_kind());
          scan_start(CH_E, (p > 0) ? p - 1'b1 : p);
          scan_byte(c, p);
        end
      ST_FRAC0:
        if (digit_c(c)) begin lx_state = ST_FRAC; keep_byte(c); end
        else begin close_tok(num_kind()); scan_start(c, p); end
      ST_FRAC:
        if (digit_c(c)) keep_byte(c);
        else if (c == CH_E) begin lx_state = ST_EXP0; keep_byte(c); end
        else begin close_tok(num_kind()); scan_start(c, p); end
      ST_EXP0:
        if (digit_c(c)) begin lx_state = ST_EXP; keep_byte(c); end
        else if (c == CH_PLUS || c == CH_MINUS) begin lx_state = ST_EXP_SGN; keep_byte(c); end
        else begin close_tok(num_kind()); scan_start(c, p); end
      ST_EXP_SGN:
        if (digit_c(c)) begin lx_state = ST_EXP; keep_byte(c); end
        else begin put_error(ERR_EXP_SIGN, p); scan_start(c, p); end
      ST_EXP:
        if (digit_c(c)) keep_byte(c);
        else begin close_tok(num_kind()); scan_start(c, p); end
      ST_STR: begin
        tok_len = inc_sat(tok_len);
        if (c == CH_BSLASH) lx_state = ST_STR_BS;
        else if (c == CH_QUOTE) close_tok(TK_STRING);
        else put_byte(c);
      end
      ST_STR_BS:
        if (c == CH_BSLASH || c == CH_N || c == CH_R) begin
          tok_len = inc_sat(tok_len);
          put_byte(c == CH_N ? CH_LF : (c == CH_R ? CH_CR : c));
          lx_state = ST_STR;
        end else begin
          put_error(ERR_ESCAPE, p); lx_state = ST_START;
        end
      ST_OP: begin
        k = TK_NONE;
        if (c == CH_EQ) begin
          case (op_first)
            CH_EQ: k = TK_EQ; CH_BANG: k = TK_NE; CH_LT: k = TK_LE; CH_GT: k = TK_GE;
            default: k = TK_NONE;
          endcase
        end else if (c == op_first) begin
          case (op_first)
            CH_AMP: k = TK_AND; CH_BAR: k = TK_OR; CH_COLON: k = TK_DCOLON;
            default: k = TK_NONE;
          endcase
        end
        if (k != TK_NONE) begin
          put_byte(op_first); put_byte(c); tok_len = 2; close_tok(k);
        end else begin
          put_token(single_op(op_first), tok_start, 1);
          scan_start(c, p);
        end
      end
      default: scan_start(c, p);
    endcase
  endtask

  task automatic end_source();
    case (lx_state)
      ST_ID, ST_ID_U: close_tok(TK_ID);
      ST_WHOLE, ST_FRAC0, ST_FRAC, ST_EXP0, ST_EXP: close_tok(num_kind());
      ST_WHOLE_E: begin
        close_tok(num_kind());
        scan_start(CH_E, (src_pos > 0) ? src_pos - 1'b1 : src_pos);
        close_tok(TK_ID);
      end
      ST_EXP_SGN: put_error(ERR_EXP_SIGN, src_pos);
      ST_STR, ST_STR_BS: put_error(ERR_UNCLOSED, src_pos);
      ST_OP: put_token(single_op(op_first), tok_start, 1);
      default: ;
    endcase
    put_token(TK_EOF, src_pos, 0);
    lx_state = ST_START; num_float = 0; src_pos = 0;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  word_t w;
  always @(posedge clk) begin
    if (!rst_n) begin
      lx_state = ST_START; op_first = 0; num_float = 0;
      tok_start = 0; tok_len = 0; src_pos = 0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        step_words.delete();
        if (in_end_of_input) end_source();
        else begin
          scan_byte(in_char_byte, src_pos);
          src_pos = inc_sat(src_pos);
        end
        if (step_words.size() > 0) step_words[step_words.size()-1].last = 1;
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) report("unexpected word", 32'(out_kind), 0);
        else begin
          w = expected_words.pop_front();
          if (out_kind !== w.r.kind)
            report("kind", 32'(out_kind), 32'(w.r.kind));
          if (out_value_byte !== w.r.vbyte)
            report("value byte", 32'(out_value_byte), 32'(w.r.vbyte));
          if (out_token_kind !== w.r.tkind)
            report("token kind", 32'(out_token_kind), 32'(w.r.tkind));
          if (out_token_start !== w.r.tstart)
            report("start", 32'(out_token_start), 32'(w.r.tstart));
          if (out_token_length !== w.r.tlen)
            report("length", 32'(out_token_length), 32'(w.r.tlen));
          if (out_error_code !== w.r.ecode)
            report("error code", 32'(out_error_code), 32'(w.r.ecode));
          if (out_last_of_run !== w.last)
            report("last", 32'(out_last_of_run), 32'(w.last));
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - top level for the source text tokenizer
// Drives directed and random source text with random gaps and stalls.
// ============================================================================
// The sender pushes bytes and end markers; the receiver waits a random
// number of cycles per word and once holds off for a long stretch so the
// batch queue fills and in_stall rises. All checking lives in stt_checker;
// this top only makes stimulus and gives the verdict.
module testbench import stt_pkg::*; ();

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 0;
  logic        in_end_of_input = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [1:0]  out_kind;
  logic [7:0]  out_value_byte;
  logic [5:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;
  int          fail_count;
  int          pending_words;
  int          cycle_count = 0;
  int          sent_items = 0;
  int          rx_wait = 0;
  int          rx_draw;
  bit          hold_off_req = 0;

  // 20 ns clock
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  source_text_tokenizer_unit u_top (.*);

  stt_checker u_chk (.*);

  // watchdog: worst case is far below this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // sender
  // -------------------------------------------------------------------------
  // one word: an optional random idle gap, then hold valid until accepted
  task automatic send(logic [7:0] b, logic eoi, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;   // stretches of back-to-back words
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_char_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send(s[i], 0);
  endtask

  // a random lexeme, well-formed or not, with random content
  task automatic send_lexeme();
    int n;
    byte ops[16];
    ops = '{"=", "!", "<", ">", "&", "|", ":", "+", "-", "*", "/", "^", "(", ";", "}", "."};
    case ($urandom_range(0, 7))
      0: begin   // identifier
        send(8'("a" + $urandom_range(0, 25)), 0);
        repeat ($urandom_range(0, 4)) send(8'($urandom_range(0, 1) ? "0" + $urandom_range(0, 9)
                                                                   : "_"), 0);
      end
      1: begin   // number, maybe float / exponent
        repeat ($urandom_range(1, 3)) send(8'("0" + $urandom_range(0, 9)), 0);
        if ($urandom_range(0, 1)) begin
          send(".", 0);
          repeat ($urandom_range(0, 2)) send(8'("0" + $urandom_range(0, 9)), 0);
        end
        if ($urandom_range(0, 1)) begin
          send("e", 0);
          if ($urandom_range(0, 1)) send($urandom_range(0, 1) ? "+" : "-", 0);
          repeat ($urandom_range(0, 2)) send(8'("0" + $urandom_range(0, 9)), 0);
        end
      end
      2: begin   // string with escapes
        send(CH_QUOTE, 0);
        repeat ($urandom_range(0, 4)) begin
          n = $urandom_range(0, 5);
          if (n == 0) begin
            send(CH_BSLASH, 0);
            case ($urandom_range(0, 3))
              0: send(CH_N, 0); 1: send(CH_R, 0); 2: send(CH_BSLASH, 0);
              default: send(8'($urandom_range(0, 255)), 0);
            endcase
          end else send(8'($urandom_range(8'h20, 8'h7e) == CH_QUOTE ? "q"
                           : $urandom_range(8'h23, 8'h5b)), 0);
        end
        if ($urandom_range(0, 5) != 0) send(CH_QUOTE, 0);
      end
      3: begin   // one or two char operator
        send(ops[$urandom_range(0, 15)], 0);
        if ($urandom_range(0, 1)) send($urandom_range(0, 1) ? "=" : ops[$urandom_range(0, 6)], 0);
      end
      4: send("_", 0);
      5: send($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 0);
      6: send($urandom_range(0, 1) ? CH_LF : ",", 0);
      default: send(8'($urandom_range(0, 255)), 0);   // noise, high bytes included
    endcase
  endtask

  // -------------------------------------------------------------------------
  // receiver: a random wait drawn per word, plus one long hold-off
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1;
      rx_wait   <= 0;
    end else if (hold_off_req) begin
      out_stall <= 1;
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else if (out_valid && !out_stall) begin
      rx_draw    = $urandom_range(0, 14);
      rx_wait   <= rx_draw;
      out_stall <= (rx_draw > 0);
    end else begin
      out_stall <= 0;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes of every token class and each special case
    send_text("ab_9 Z");          // id, space skip, end of id
    send_text("12e5 3e+ 4ex");    // exponent, sign without digit, e lookahead
    send_text("1.5e-2 7. ");      // float, dangling dot
    send(8'hff, 0); send(8'h00, 0); send(CH_CR, 0);   // bad chars
    send_text("_a __ _1");        // underscore rule
    send_text("\"a\\n\\r\\\\\\q"); // escapes and a bad escape
    send_text("== != <= >= && || :: = ! < > & | : +-*/^()\n,;[]{}.");
    send_text("\"open");
    send(0, 1);                   // unclosed string at end
    send_text("9e");
    send(8'hff, 1);               // held e at end, char ignored

    // long receiver hold-off while the sender keeps pushing
    fork
      begin
        hold_off_req = 1;
        repeat (120) @(posedge clk);
        hold_off_req = 0;
      end
      repeat (12) send("x", 0, 1);
    join

    while (sent_items < 228) begin
      send_lexeme();
      if ($urandom_range(0, 25) == 0) send(8'($urandom_range(0, 255)), 1);
    end
    send(0, 1);
    in_valid <= 0;

    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: files.f
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_back.sv
sv/source_text_tokenizer_unit.sv
verif/stt_checker.sv
verif/testbench.sv
